>>> hdl/cwsm_pkg.sv
// ----------------------------------------------------------------------------
// cwsm_pkg
// shared types, constants and the weight table of the 5x5 cone smoothing block
// ----------------------------------------------------------------------------
package cwsm_pkg;

    localparam int DEF_MAX_ROW_LENGTH = 2048;
    localparam int DEF_MAX_ROWS       = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int ROW_LEN_W  = 12;
    localparam int ROW_CNT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 1'd1;

    localparam int WEIGHT_W  = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 35;
    localparam int TSUM_W    = 18;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic shift;
        logic mac;
        logic div_start;
        logic div_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ignore;
        logic emit;
        logic mac_done;
        logic div_done;
        logic out_free;
    } status_t;

    // q1.15 weights, max(0, 1 - 0.4*distance), by row and column offset + 2
    function automatic logic [WEIGHT_W-1:0] weight(input logic [2:0] k, input logic [2:0] j);
        logic [2:0] dk;
        logic [2:0] dj;
        logic [WEIGHT_W-1:0] w;
        dk = (k > 3'd2) ? k - 3'd2 : 3'd2 - k;
        dj = (j > 3'd2) ? j - 3'd2 : 3'd2 - j;
        w = 16'd0;
        case ({dk, dj})
            6'o00: w = 16'd32768;
            6'o01, 6'o10: w = 16'd19661;
            6'o11: w = 16'd14232;
            6'o02, 6'o20: w = 16'd6554;
            6'o12, 6'o21: w = 16'd3459;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

>>> hdl/cwsm_ctrl.sv
// ----------------------------------------------------------------------------
// cwsm_ctrl
// sequencer: read line store, shift window, accumulate, divide, hand over
// ----------------------------------------------------------------------------
module cwsm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cwsm_pkg::status_t status,
    output cwsm_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_MAC    = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && !status.ignore) begin
                    cmd.take   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.shift  = 1'b1;
                state_next = status.emit ? ST_MAC : ST_IDLE;
            end
            ST_MAC: begin
                cmd.mac = 1'b1;
                if (status.mac_done) begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/cwsm_datapath.sv
// ----------------------------------------------------------------------------
// cwsm_datapath
// line store, 5x5 window, shared multiplier, bit-serial divider, output slot
// ----------------------------------------------------------------------------
module cwsm_datapath #(
    parameter int MAX_ROW_LENGTH = cwsm_pkg::DEF_MAX_ROW_LENGTH,
    parameter int MAX_ROWS       = cwsm_pkg::DEF_MAX_ROWS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [cwsm_pkg::SAMPLE_W-1:0]      s_sample,
    input  logic                               s_flush,
    output logic [cwsm_pkg::SAMPLE_W-1:0]      m_filtered,
    output logic                               m_row_end,
    output logic                               m_frame_end,
    output logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               cfg_we,
    input  logic [cwsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cwsm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  cwsm_pkg::cmd_t                     cmd,
    output cwsm_pkg::status_t                  status
);

    localparam int CW  = $clog2(MAX_ROW_LENGTH);
    localparam int WW  = CW + 1;
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int HW  = RW + 1;
    localparam int IRW = RW + 2;
    localparam int SW  = cwsm_pkg::SAMPLE_W;

    logic [cwsm_pkg::ROW_LEN_W-1:0] row_length_reg;
    logic [cwsm_pkg::ROW_CNT_W-1:0] row_count_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic [CW-1:0]  in_col_reg;
    logic [IRW-1:0] in_row_reg;
    logic [CW-1:0]  out_col_reg;
    logic [RW-1:0]  out_row_reg;

    logic [4*SW-1:0] store_mem [MAX_ROW_LENGTH];
    logic [4*SW-1:0] rd_reg;
    logic [SW-1:0]   sample_reg;
    logic [SW-1:0]   window_reg [5][5];

    logic [4:0] mac_cnt_reg;
    logic [2:0] mk_reg;
    logic [2:0] mj_reg;
    logic [cwsm_pkg::PROD_W-1:0] prod_reg;
    logic [cwsm_pkg::ACC_W-1:0]  acc_reg;
    logic [cwsm_pkg::TSUM_W-1:0] tsum_reg;

    logic [cwsm_pkg::TSUM_W:0]   rem_reg;
    logic [SW-1:0]               nlow_reg;
    logic [SW-1:0]               quot_reg;
    logic [3:0]                  dcnt_reg;

    logic            out_valid_reg;
    logic [SW-1:0]   out_data_reg;
    logic            out_row_end_reg;
    logic            out_frame_end_reg;

    logic draining;
    logic emit;
    logic in_row_last;
    logic row_last;
    logic frame_last;
    logic restart;
    logic [WW:0]     xs;
    logic [HW:0]     ys;
    logic            in_bounds;
    logic [cwsm_pkg::WEIGHT_W-1:0] wgt;
    logic [cwsm_pkg::ACC_W-1:0]    num;
    logic [cwsm_pkg::TSUM_W:0]     trial;

    // clamp sizes into the supported range
    always_comb begin
        if (row_length_reg < 12'd3) begin
            w_eff = WW'(3);
        end else if (32'(row_length_reg) > 32'(MAX_ROW_LENGTH)) begin
            w_eff = WW'(MAX_ROW_LENGTH);
        end else begin
            w_eff = WW'(row_length_reg);
        end
        if (row_count_reg < 13'd3) begin
            h_eff = HW'(3);
        end else if (32'(row_count_reg) > 32'(MAX_ROWS)) begin
            h_eff = HW'(MAX_ROWS);
        end else begin
            h_eff = HW'(row_count_reg);
        end
    end

    assign draining    = in_row_reg >= IRW'(h_eff);
    assign emit        = (in_row_reg > IRW'(2)) ||
                         ((in_row_reg == IRW'(2)) && (in_col_reg >= CW'(2)));
    assign in_row_last = (WW'(in_col_reg) + WW'(1)) >= w_eff;
    assign row_last    = (WW'(out_col_reg) + WW'(1)) >= w_eff;
    assign frame_last  = row_last && ((HW'(out_row_reg) + HW'(1)) >= h_eff);
    assign restart     = (cfg_we && (cfg_index == cwsm_pkg::REG_ROW_LENGTH ||
                                     cfg_index == cwsm_pkg::REG_ROW_COUNT)) ||
                         (cmd.load_out && frame_last);

    // neighbour position test, offsets taken as counter minus two
    assign xs = (WW+1)'(out_col_reg) + (WW+1)'(mj_reg);
    assign ys = (HW+1)'(out_row_reg) + (HW+1)'(mk_reg);
    assign in_bounds = (xs >= (WW+1)'(2)) && (xs < ((WW+1)'(w_eff) + (WW+1)'(2))) &&
                       (ys >= (HW+1)'(2)) && (ys < ((HW+1)'(h_eff) + (HW+1)'(2)));
    assign wgt = in_bounds ? cwsm_pkg::weight(mk_reg, mj_reg) : '0;

    assign num   = acc_reg + cwsm_pkg::ACC_W'(tsum_reg >> 1);
    assign trial = {rem_reg[cwsm_pkg::TSUM_W-1:0], nlow_reg[SW-1]};

    assign status.ignore   = s_flush && !draining;
    assign status.emit     = emit;
    assign status.mac_done = (mac_cnt_reg == 5'd25);
    assign status.div_done = (dcnt_reg == 4'd15);
    assign status.out_free = !out_valid_reg || m_ready;

    // configuration registers and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= cwsm_pkg::ROW_LEN_W'(1025);
            row_count_reg  <= cwsm_pkg::ROW_CNT_W'(1025);
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
        end else begin
            if (cfg_we && cfg_index == cwsm_pkg::REG_ROW_LENGTH) begin
                row_length_reg <= cfg_data[cwsm_pkg::ROW_LEN_W-1:0];
            end
            if (cfg_we && cfg_index == cwsm_pkg::REG_ROW_COUNT) begin
                row_count_reg <= cfg_data;
            end
            if (restart) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                if (cmd.shift) begin
                    if (in_row_last) begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + IRW'(1);
                    end else begin
                        in_col_reg <= in_col_reg + CW'(1);
                    end
                end
                if (cmd.load_out) begin
                    if (row_last) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + RW'(1);
                    end else begin
                        out_col_reg <= out_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    // line store: four earlier rows packed per column
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            rd_reg     <= store_mem[in_col_reg];
            sample_reg <= draining ? '0 : s_sample;
        end
        if (cmd.shift) begin
            store_mem[in_col_reg] <= {sample_reg, rd_reg[4*SW-1:SW]};
        end
    end

    // window shifts one column left, new column enters on the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 5; k++) begin
                for (int j = 0; j < 5; j++) begin
                    window_reg[k][j] <= '0;
                end
            end
        end else if (cmd.shift) begin
            for (int k = 0; k < 5; k++) begin
                for (int j = 0; j < 4; j++) begin
                    window_reg[k][j] <= window_reg[k][j+1];
                end
            end
            for (int k = 0; k < 4; k++) begin
                window_reg[k][4] <= rd_reg[k*SW +: SW];
            end
            window_reg[4][4] <= sample_reg;
        end
    end

    // one product a cycle, accumulated in the cycle after
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_cnt_reg <= '0;
            mk_reg      <= '0;
            mj_reg      <= '0;
        end else if (cmd.shift) begin
            mac_cnt_reg <= '0;
            mk_reg      <= '0;
            mj_reg      <= '0;
        end else if (cmd.mac && mac_cnt_reg != 5'd25) begin
            mac_cnt_reg <= mac_cnt_reg + 5'd1;
            if (mj_reg == 3'd4) begin
                mj_reg <= '0;
                mk_reg <= mk_reg + 3'd1;
            end else begin
                mj_reg <= mj_reg + 3'd1;
            end
        end
    end

    // neighbours outside the grid contribute nothing, whatever the window holds
    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            acc_reg  <= '0;
            tsum_reg <= '0;
        end else if (cmd.mac) begin
            if (mac_cnt_reg != 5'd25) begin
                prod_reg <= in_bounds ? window_reg[mk_reg][mj_reg] * wgt : '0;
                tsum_reg <= tsum_reg + cwsm_pkg::TSUM_W'(wgt);
            end
            if (mac_cnt_reg != 5'd0) begin
                acc_reg <= acc_reg + cwsm_pkg::ACC_W'(prod_reg);
            end
        end
    end

    // restoring division, one quotient bit a cycle, msb first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg  <= num[cwsm_pkg::ACC_W-1:SW];
            nlow_reg <= num[SW-1:0];
            quot_reg <= '0;
        end else if (cmd.div_step) begin
            nlow_reg <= {nlow_reg[SW-2:0], 1'b0};
            if (trial >= (cwsm_pkg::TSUM_W+1)'(tsum_reg)) begin
                rem_reg  <= trial - (cwsm_pkg::TSUM_W+1)'(tsum_reg);
                quot_reg <= {quot_reg[SW-2:0], 1'b1};
            end else begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[SW-2:0], 1'b0};
            end
        end
    end

    // output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg      <= quot_reg;
            out_row_end_reg   <= row_last;
            out_frame_end_reg <= frame_last;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_filtered  = out_data_reg;
    assign m_row_end   = out_row_end_reg;
    assign m_frame_end = out_frame_end_reg;

endmodule

>>> hdl/cone_weighted_5x5_smoothing_top.sv
// ----------------------------------------------------------------------------
// cone_weighted_5x5_smoothing_top
// 5x5 cone-weighted smoothing of a raster height stream with border renorm
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata         | tlast   | tuser
//  ---------+-----------+---------------+---------+----------
//  s_       | in        | sample[15:0]  | -       | flush
//  m_       | out       | filtered[15:0]| row_end | frame_end
//  cfg_     | in        | cfg_data: row_length (index 0), row_count (index 1)
//
//  sequence: a sample transaction that yields no result is accepted, then
//  read from the line store and shifted into the window; otherwise it goes on
//  to the multiply-accumulate steps on one shared multiplier with the last
//  add, the rounding add and divider load, the bit-serial division and the
//  hand-over into the output slot; a flush before the frame's end is
//  dropped in its accept cycle
//  reset: aresetn synchronous active low, clears control state and window;
//  the line store needs no clearing, unwritten entries fall outside the grid
//  stalls: a finished result waits in the output slot while the next
//  transaction is already accepted and worked on
//
module cone_weighted_5x5_smoothing_top #(
    parameter int MAX_ROW_LENGTH = cwsm_pkg::DEF_MAX_ROW_LENGTH,
    parameter int MAX_ROWS       = cwsm_pkg::DEF_MAX_ROWS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] sample
    input  logic                              s_tuser,   // [0] flush
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] filtered
    output logic                              m_tlast,   // row_end
    output logic                              m_tuser,   // [0] frame_end
    // configuration writes, only while idle
    input  logic                              cfg_we,
    input  logic [cwsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cwsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    cwsm_pkg::cmd_t    cmd;
    cwsm_pkg::status_t status;

    // sequencer
    cwsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage, arithmetic and output slot
    cwsm_datapath #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .MAX_ROWS       (MAX_ROWS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_sample    (s_tdata),
        .s_flush     (s_tuser),
        .m_filtered  (m_tdata),
        .m_row_end   (m_tlast),
        .m_frame_end (m_tuser),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

>>> hdl/cwsm_checker.sv
// ----------------------------------------------------------------------------
// cwsm_checker
// port-level checks of the smoothing block, bound to the top level
// ----------------------------------------------------------------------------
module cwsm_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic s_tuser,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast,
    input logic m_tuser
);

    // a result waiting for the sink stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // the last result of the frame also ends its row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without row end");

    // after an accepted sample that is not a flush, the block is busy and drops s_tready
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> !s_tready)
        else $error("sample accepted back to back");

    // reset leaves no result offered
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind cone_weighted_5x5_smoothing_top cwsm_checker u_cwsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
